FILE: design/merkle_proof_verifier_core_macros.svh
// assertion macros of the merkle proof verifier rtl
`ifndef MERKLE_PROOF_VERIFIER_CORE_MACROS_SVH
`define MERKLE_PROOF_VERIFIER_CORE_MACROS_SVH

`ifndef SYNTH

// clocked assertion, switched off while reset is asserted
`define MPV_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed in merkle proof verifier");

// clocked assertion that also holds during reset
`define MPV_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed in merkle proof verifier");

`else

`define MPV_ASSERT(label, clk, rst_n, prop)
`define MPV_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: design/mpv_pkg.sv
// constants, register map and helper function of the merkle proof verifier
package mpv_pkg;

	localparam int HASH_W  = 32;
	localparam int NIB_W   = 4;
	localparam int CHAR_W  = 8;
	localparam int NIB_N   = HASH_W / NIB_W;
	localparam int CHAR_N  = 2 * NIB_N;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// register index taken from paddr above the byte offset
	localparam logic [0:0] REG_EXPECTED_ROOT = 1'b0;

	// ascii codes of the lowercase hex digits
	localparam logic [CHAR_W-1:0] ASCII_ZERO     = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_A_MINUS_10 = 8'h57;

	// one nibble as a lowercase ascii hex character
	function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
		logic [CHAR_W-1:0] wide;
		wide = {{(CHAR_W-NIB_W){1'b0}}, nib};
		if (nib < 4'd10)
			return ASCII_ZERO + wide;
		else
			return ASCII_A_MINUS_10 + wide;
	endfunction

endpackage

FILE: design/mpv_stream_if.sv
// request and result channel interfaces of the merkle proof verifier

interface mpv_req_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [mpv_pkg::HASH_W-1:0]  hash_value;
	logic                        last;

	modport source (output valid, output mode, output hash_value, output last,
		input ready);
	modport sink (input valid, input mode, input hash_value, input last,
		output ready);
endinterface

interface mpv_res_if;
	logic                        valid;
	logic                        ready;
	logic [mpv_pkg::HASH_W-1:0]  computed_root;
	logic                        matches_res;

	modport source (output valid, output computed_root, output matches_res,
		input ready);
	modport sink (input valid, input computed_root, input matches_res,
		output ready);
endinterface

FILE: design/mpv_apb_regs.sv
// apb configuration register block holding the expected root
module mpv_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mpv_pkg::APB_AW-1:0]  paddr,
	input  logic [mpv_pkg::APB_DW-1:0]  pwdata,
	output logic [mpv_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [mpv_pkg::HASH_W-1:0]  expected_root
);

	logic                        wr_en;
	logic [mpv_pkg::HASH_W-1:0]  expected_root_q;

	// no wait states
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// register write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_root_q <= '0;
		end else if (wr_en && (paddr[mpv_pkg::APB_AW-1] == mpv_pkg::REG_EXPECTED_ROOT)) begin
			expected_root_q <= pwdata[mpv_pkg::HASH_W-1:0];
		end
	end

	// read decode
	always_comb begin
		unique case (paddr[mpv_pkg::APB_AW-1])
			mpv_pkg::REG_EXPECTED_ROOT: prdata = expected_root_q;
			default:                    prdata = '0;
		endcase
	end

	assign expected_root = expected_root_q;

endmodule

FILE: design/mpv_hash_unit.sv
// combinational pair hash: ordered hex characters folded by xor and rotate
module mpv_hash_unit (
	input  logic [mpv_pkg::HASH_W-1:0] running,
	input  logic [mpv_pkg::HASH_W-1:0] sibling,
	output logic [mpv_pkg::HASH_W-1:0] pair_hash
);

	logic [mpv_pkg::HASH_W-1:0]   lo_word;
	logic [mpv_pkg::HASH_W-1:0]   hi_word;
	logic [2*mpv_pkg::HASH_W-1:0] pair_word;
	logic [mpv_pkg::CHAR_W-1:0]   chr [mpv_pkg::CHAR_N];

	// smaller hash goes first
	assign lo_word   = (running <= sibling) ? running : sibling;
	assign hi_word   = (running <= sibling) ? sibling : running;
	assign pair_word = {lo_word, hi_word};

	// hex characters, most significant nibble first
	always_comb begin
		for (int i = 0; i < mpv_pkg::CHAR_N; i++) begin
			chr[i] = mpv_pkg::hex_char(pair_word[2*mpv_pkg::HASH_W-1-mpv_pkg::NIB_W*i -:
				mpv_pkg::NIB_W]);
		end
	end

	// each character ends up rotated once per remaining step; the
	// rotations never wrap so a plain shift places it
	always_comb begin
		pair_hash = '0;
		for (int i = 0; i < mpv_pkg::CHAR_N; i++) begin
			pair_hash = pair_hash ^
				({{(mpv_pkg::HASH_W-mpv_pkg::CHAR_W){1'b0}}, chr[i]} << (mpv_pkg::CHAR_N - i));
		end
	end

endmodule

FILE: design/mpv_pipe.sv
// request register, running hash and result register of the verifier
`include "merkle_proof_verifier_core_macros.svh"

module mpv_pipe (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [mpv_pkg::HASH_W-1:0] expected_root,
	mpv_req_if.sink                    req_ch,
	mpv_res_if.source                  res_ch
);

	logic                       valid_s1;
	logic                       mode_s1;
	logic [mpv_pkg::HASH_W-1:0] hash_s1;
	logic                       last_s1;

	logic [mpv_pkg::HASH_W-1:0] running_q;
	logic                       res_valid_q;
	logic [mpv_pkg::HASH_W-1:0] root_q;
	logic                       matches_q;

	logic                       res_free;
	logic                       adv_s1;
	logic [mpv_pkg::HASH_W-1:0] mixed_hash;
	logic [mpv_pkg::HASH_W-1:0] next_hash;

	mpv_hash_unit u_hash (
		.running   (running_q),
		.sibling   (hash_s1),
		.pair_hash (mixed_hash)
	);

	// flow control: a request moves on unless its result has nowhere to go
	assign res_free     = !res_valid_q || res_ch.ready;
	assign adv_s1       = valid_s1 && (!last_s1 || res_free);
	assign req_ch.ready = !valid_s1 || adv_s1;

	assign next_hash = mode_s1 ? mixed_hash : hash_s1;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ch.ready) begin
			valid_s1 <= req_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ch.ready && req_ch.valid) begin
			mode_s1 <= req_ch.mode;
			hash_s1 <= req_ch.hash_value;
			last_s1 <= req_ch.last;
		end
	end

	// running hash update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
		end else if (adv_s1) begin
			running_q <= next_hash;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= adv_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && adv_s1 && last_s1) begin
			root_q    <= next_hash;
			matches_q <= (next_hash == expected_root);
		end
	end

	assign res_ch.valid         = res_valid_q;
	assign res_ch.computed_root = root_q;
	assign res_ch.matches_res   = matches_q;

	// checks
	`MPV_ASSERT(a_leaf_load, clk, arst_n,
		(adv_s1 && !mode_s1) |=> (running_q == $past(hash_s1)))
	`MPV_ASSERT(a_last_gives_result, clk, arst_n,
		(adv_s1 && last_s1) |=> (res_valid_q && (root_q == running_q)))
	`MPV_ASSERT(a_blocked_last_stalls, clk, arst_n,
		(valid_s1 && last_s1 && res_valid_q && !res_ch.ready) |-> !req_ch.ready)
	`MPV_ASSERT_ALWAYS(a_idle_ready, clk,
		!valid_s1 |-> req_ch.ready)

endmodule

FILE: design/merkle_proof_verifier_core.sv
// top level of the merkle proof verifier
//
//  channel   dir  handshake            payload
//  req_ch    in   valid / ready        mode, hash_value, last
//  res_ch    out  valid / ready        computed_root, matches_res
//  apb       in   psel/penable/pready  expected_root at byte address 0
//
// one request per cycle unless a last request waits on a pending result;
// a last request's root passes from the request register to the result one
// reset clears the expected root, the running hash and all valid flags
// a pending result that is not taken only stalls a following last request
module merkle_proof_verifier_core (
	input  logic                       clk,
	input  logic                       arst_n,
	mpv_req_if.sink                    req_ch,
	mpv_res_if.source                  res_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mpv_pkg::APB_AW-1:0] paddr,
	input  logic [mpv_pkg::APB_DW-1:0] pwdata,
	output logic [mpv_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	logic [mpv_pkg::HASH_W-1:0] expected_root;

	// configuration registers
	mpv_apb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.expected_root (expected_root)
	);

	// proof datapath
	mpv_pipe u_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.expected_root (expected_root),
		.req_ch        (req_ch),
		.res_ch        (res_ch)
	);

endmodule

FILE: sim/merkle_proof_verifier_core_tb.sv
// testbench of the merkle proof verifier core: directed and random proofs against a predictor
`timescale 1ns / 1ps

module merkle_proof_verifier_core_tb;

	localparam int         HOLD_CYCLES  = 400;
	localparam int         PHASES       = 12;
	localparam int         PHASE_ITEMS  = 158;
	localparam int         DRAIN_CYCLES = 4;
	localparam logic [0:0] REG_SPARE    = 1'b1;

	typedef struct packed {
		logic [mpv_pkg::HASH_W-1:0] root;
		logic                       hit;
	} root_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [mpv_pkg::APB_AW-1:0] paddr;
	logic [mpv_pkg::APB_DW-1:0] pwdata;
	logic [mpv_pkg::APB_DW-1:0] prdata;
	logic pready;

	mpv_req_if req_ch ();
	mpv_res_if res_ch ();

	merkle_proof_verifier_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_ch  (req_ch),
		.res_ch  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state and pending roots
	logic [mpv_pkg::HASH_W-1:0] chain_hash;
	logic [mpv_pkg::HASH_W-1:0] root_cfg;
	root_t                      root_q[$];
	int                         errors;
	int                         reqs_sent;
	int                         burst_left;
	bit                         hold_req;

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// run limit
	initial begin
		#(5_000_000);
		$display("** merkle_proof_verifier_core: FAILED **");
		$finish;
	end

	// xor-rotate digest over the 16 hex characters, smaller hash first
	function automatic logic [mpv_pkg::HASH_W-1:0] pair_digest(
		input logic [mpv_pkg::HASH_W-1:0] a,
		input logic [mpv_pkg::HASH_W-1:0] b);
		logic [mpv_pkg::HASH_W-1:0] lo;
		logic [mpv_pkg::HASH_W-1:0] hi;
		logic [mpv_pkg::HASH_W-1:0] acc;
		logic [2*mpv_pkg::HASH_W-1:0] pair;
		logic [3:0] nib;
		logic [7:0] ch;
		lo = (a <= b) ? a : b;
		hi = (a <= b) ? b : a;
		pair = {lo, hi};
		acc = '0;
		for (int k = 15; k >= 0; k--) begin
			nib = pair[4*k +: 4];
			ch = (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h61 + 8'(nib) - 8'd10;
			acc = acc ^ {24'b0, ch};
			acc = {acc[mpv_pkg::HASH_W-2:0], acc[mpv_pkg::HASH_W-1]};
		end
		return acc;
	endfunction

	// advance the predictor by one accepted request
	task automatic apply_request(input logic mode, input logic [mpv_pkg::HASH_W-1:0] hv,
		input logic last);
		if (mode == 1'b0)
			chain_hash = hv;
		else
			chain_hash = pair_digest(chain_hash, hv);
		if (last)
			root_q.push_back('{root: chain_hash, hit: (chain_hash == root_cfg)});
	endtask

	task automatic flag_mismatch(input string what, input logic [mpv_pkg::HASH_W-1:0] got,
		input logic [mpv_pkg::HASH_W-1:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	// offer one request in bursts with random gaps between them
	task automatic push_request(input logic mode, input logic [mpv_pkg::HASH_W-1:0] hv,
		input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 6);
				@(negedge clk);
				req_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_ch.valid      = 1'b1;
		req_ch.mode       = mode;
		req_ch.hash_value = hv;
		req_ch.last       = last;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		apply_request(mode, hv, last);
		reqs_sent++;
	endtask

	// stop offering and let every pending root come out
	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (root_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write, then read back the root register
	task automatic write_cfg(input logic [0:0] index,
		input logic [mpv_pkg::HASH_W-1:0] value);
		logic [mpv_pkg::APB_DW-1:0] got;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = mpv_pkg::APB_AW'({index, 2'b00});
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (index == mpv_pkg::REG_EXPECTED_ROOT)
			root_cfg = value;
		@(negedge clk);
		pwrite  = 1'b0;
		penable = 1'b0;
		paddr   = mpv_pkg::APB_AW'({mpv_pkg::REG_EXPECTED_ROOT, 2'b00});
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		got = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (got !== root_cfg)
			flag_mismatch("expected_root readback", got, root_cfg);
	endtask

	// hash with a bias towards the extremes and the current running hash
	function automatic logic [mpv_pkg::HASH_W-1:0] pick_hash();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return '1;
			2: return chain_hash;
			default: return $urandom;
		endcase
	endfunction

	// one proof, mostly well formed, otherwise loose requests
	task automatic send_random_proof(input int max_sibs);
		int k;
		int n;
		if ($urandom_range(0, 99) < 85) begin
			k = $urandom_range(0, max_sibs);
			push_request(1'b0, pick_hash(), k == 0);
			for (int i = 0; i < k; i++)
				push_request(1'b1, pick_hash(), i == k - 1);
		end else begin
			n = $urandom_range(1, 4);
			repeat (n)
				push_request(1'($urandom_range(0, 1)), $urandom,
					1'($urandom_range(0, 1)));
		end
	endtask

	// corner cases of the proof chain under the reset root
	task automatic test_proof_corners();
		// sibling before any leaf combines with the reset hash
		push_request(1'b1, 32'h12345678, 1'b1);
		// lone leaves at the extremes, the zero one matches the reset root
		push_request(1'b0, 32'h00000000, 1'b1);
		push_request(1'b0, 32'hffffffff, 1'b1);
		// equal hashes
		push_request(1'b0, 32'h0000ffff, 1'b0);
		push_request(1'b1, 32'h0000ffff, 1'b1);
		// both orders of the pair, extremes as siblings
		push_request(1'b0, 32'h89abcdef, 1'b0);
		push_request(1'b1, 32'h01234567, 1'b0);
		push_request(1'b1, 32'hffffffff, 1'b0);
		push_request(1'b1, 32'h00000000, 1'b1);
		// sibling continuing from the previous proof
		push_request(1'b1, 32'hdeadbeef, 1'b1);
		wait_idle();
	endtask

	// all-ones root, spare index write and a predicted match
	task automatic test_root_register();
		logic [mpv_pkg::HASH_W-1:0] r;
		write_cfg(mpv_pkg::REG_EXPECTED_ROOT, 32'hffffffff);
		push_request(1'b0, 32'hffffffff, 1'b1);
		wait_idle();
		// write to the unused index leaves the root alone
		write_cfg(REG_SPARE, 32'h00000000);
		push_request(1'b0, 32'hffffffff, 1'b1);
		wait_idle();
		r = pair_digest(32'hcafef00d, 32'h0badf00d);
		write_cfg(mpv_pkg::REG_EXPECTED_ROOT, r);
		push_request(1'b0, 32'hcafef00d, 1'b0);
		push_request(1'b1, 32'h0badf00d, 1'b1);
		wait_idle();
	endtask

	// long receiver hold-off while short proofs keep coming
	task automatic test_backpressure();
		int start;
		@(posedge clk);
		hold_req = 1'b1;
		start = reqs_sent;
		while (reqs_sent - start < 48)
			send_random_proof(2);
		wait_idle();
	endtask

	// random proofs over several root settings
	task automatic test_random_proofs();
		int start;
		int k;
		logic [mpv_pkg::HASH_W-1:0] leaf;
		logic [mpv_pkg::HASH_W-1:0] r;
		logic [mpv_pkg::HASH_W-1:0] cfg;
		logic [mpv_pkg::HASH_W-1:0] sibs[8];
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			// first proof built ahead so its root can be the setting
			leaf = $urandom;
			k = $urandom_range(1, 8);
			r = leaf;
			for (int i = 0; i < k; i++) begin
				sibs[i] = $urandom;
				r = pair_digest(r, sibs[i]);
			end
			if (ph == 0)
				cfg = '0;
			else if (ph == 1)
				cfg = '1;
			else if (ph % 3 == 2)
				cfg = r;
			else
				cfg = $urandom;
			write_cfg(mpv_pkg::REG_EXPECTED_ROOT, cfg);
			start = reqs_sent;
			push_request(1'b0, leaf, 1'b0);
			for (int i = 0; i < k; i++)
				push_request(1'b1, sibs[i], i == k - 1);
			while (reqs_sent - start < PHASE_ITEMS)
				send_random_proof(10);
		end
		wait_idle();
	endtask

	// result receiver: changing stall patterns, plus the long hold-off
	initial begin
		int mode_sel;
		int span;
		int cnt;
		res_ch.ready = 1'b0;
		mode_sel = 0;
		span = 0;
		cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
				continue;
			end
			if (span == 0) begin
				mode_sel = $urandom_range(0, 3);
				span = $urandom_range(32, 200);
			end
			span--;
			cnt++;
			case (mode_sel)
				0: res_ch.ready = 1'b1;
				1: res_ch.ready = 1'($urandom_range(0, 1));
				2: res_ch.ready = (cnt % 5) != 0;
				default: res_ch.ready = ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		root_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (root_q.size() == 0) begin
				flag_mismatch("result with none pending", res_ch.computed_root, '0);
			end else begin
				want = root_q.pop_front();
				if (res_ch.computed_root !== want.root)
					flag_mismatch("computed_root", res_ch.computed_root, want.root);
				if (res_ch.matches_res !== want.hit)
					flag_mismatch("matches_res", {31'b0, res_ch.matches_res},
						{31'b0, want.hit});
			end
		end
	end

	// reset, tests in turn, drain and verdict
	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		req_ch.valid      = 1'b0;
		req_ch.mode       = 1'b0;
		req_ch.hash_value = '0;
		req_ch.last       = 1'b0;
		chain_hash        = '0;
		root_cfg          = '0;
		errors            = 0;
		reqs_sent         = 0;
		burst_left        = 0;
		hold_req          = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_proof_corners();
		test_root_register();
		test_backpressure();
		test_random_proofs();

		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("** merkle_proof_verifier_core: PASSED **");
		else
			$display("** merkle_proof_verifier_core: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/mpv_pkg.sv
design/mpv_stream_if.sv
design/mpv_apb_regs.sv
design/mpv_hash_unit.sv
design/mpv_pipe.sv
design/merkle_proof_verifier_core.sv
sim/merkle_proof_verifier_core_tb.sv
